FILE: hdl/tccw_pkg.sv
// Shared constants and types for the text console cell writer.
// Screen geometry, field widths, opcodes and register indexes.
// No dependencies.
package tccw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    // Fixed field widths of the ports.
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int NIB_W  = 4;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

    // Register index is taken from paddr[2].
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [NIB_W-1:0] FG_RESET = 4'h0;
    localparam logic [NIB_W-1:0] BG_RESET = 4'h7;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

endpackage

FILE: hdl/text_console_cell_writer_core.sv
// Text console cell writer: cell store, cursor and scroll/clear sequencer.
// Depends on tccw_pkg for geometry, widths and opcodes.
// A put or clear word is loaded into the output register on acceptance; a read word first
// passes through S_READ, where the store's read port result is taken. Throughput: one put
// word per cycle while the output is drained and no scroll runs; a read holds off input until
// its answer is loaded. A scroll holds off input while it copies rows up and zeroes the last
// row, a clear while it zeroes every cell (one cell per cycle). Reset: synchronous, active
// low; then a clearing pass zeroes the store, taking no word; cursor 0, fg_color 0, bg_color 7.
module text_console_cell_writer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [tccw_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_end_of_text,
    input  logic [tccw_pkg::IDX_W-1:0]  i_cell_index,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_cursor_valid,
    output logic [tccw_pkg::IDX_W-1:0]  o_cursor_index,
    output logic [tccw_pkg::CHAR_W-1:0] o_read_char,
    output logic [tccw_pkg::CHAR_W-1:0] o_read_attr,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int ADDR_W = tccw_pkg::ADDR_W;
    localparam int ROW_W  = tccw_pkg::ROW_W;
    localparam int COL_W  = tccw_pkg::COL_W;
    localparam int POS_W  = tccw_pkg::POS_W;
    localparam int CHAR_W = tccw_pkg::CHAR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_ZERO
    } t_state;

    t_state r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [tccw_pkg::NIB_W-1:0] r_fg;
    logic [tccw_pkg::NIB_W-1:0] r_bg;
    logic              r_rd_oob;

    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_cursor_valid;
    logic [tccw_pkg::IDX_W-1:0] r_cursor_index;
    logic [CHAR_W-1:0] r_read_char;
    logic [CHAR_W-1:0] r_read_attr;

    logic [15:0] mem [tccw_pkg::CELLS];
    logic [15:0] r_rd_data;

    logic              in_acc;
    logic              out_free;
    tccw_pkg::t_opcode op;
    logic              is_put;
    logic              is_nl;
    logic              in_range;
    logic [ROW_W:0]    row_a;
    logic [COL_W:0]    col_a;
    logic              ovf;
    logic [ROW_W-1:0]  new_row;
    logic [COL_W-1:0]  new_col;
    logic              wrap;
    logic [ROW_W:0]    row_rep;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] put_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              cfg_we;

    assign op       = tccw_pkg::t_opcode'(i_opcode);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_put   = (op == tccw_pkg::OP_PUT);
    assign is_nl    = (i_char_code == tccw_pkg::NEWLINE_CODE);
    assign in_range = (32'(i_cell_index) < tccw_pkg::CELLS);

    assign o_out_valid    = r_out_valid;
    assign o_cursor_valid = r_cursor_valid;
    assign o_cursor_index = r_cursor_index;
    assign o_read_char    = r_read_char;
    assign o_read_attr    = r_read_attr;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == tccw_pkg::CFG_BG) begin
            prdata[tccw_pkg::NIB_W-1:0] = r_bg;
        end else begin
            prdata[tccw_pkg::NIB_W-1:0] = r_fg;
        end
    end

    // The output register empties when drained and fills when a word is answered.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == S_READ) begin
            n_out_valid = 1'b1;
        end else if (in_acc && (op != tccw_pkg::OP_READ)) begin
            n_out_valid = 1'b1;
        end
    end

    // Cursor advance for a put, and the position reported after it.
    always_comb begin
        if (is_nl) begin
            row_a = (ROW_W+1)'(r_cur_row) + (ROW_W+1)'(1);
            col_a = '0;
        end else begin
            row_a = (ROW_W+1)'(r_cur_row);
            col_a = (COL_W+1)'(r_cur_col) + (COL_W+1)'(1);
        end
        if (col_a >= (COL_W+1)'(tccw_pkg::COLS)) begin
            col_a = '0;
            row_a = row_a + (ROW_W+1)'(1);
        end
        ovf     = (row_a >= (ROW_W+1)'(tccw_pkg::ROWS));
        new_row = ovf ? ROW_W'(tccw_pkg::ROWS - 1) : ROW_W'(row_a);
        new_col = COL_W'(col_a);
        // On the last column the cursor is shown at the start of the next row.
        wrap    = (new_col == COL_W'(tccw_pkg::COLS - 1));
        row_rep = (ROW_W+1)'(new_row) + (ROW_W+1)'(wrap);
        pos     = POS_W'(row_rep) * POS_W'(tccw_pkg::COLS)
                + (wrap ? '0 : POS_W'(new_col));
        put_addr = ADDR_W'(r_cur_row) * ADDR_W'(tccw_pkg::COLS) + ADDR_W'(r_cur_col);
    end

    // Memory port selection. The scroll copy reads one row ahead and writes the cell
    // fetched in the previous cycle, so the write trails the read by a row plus one.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = put_addr;
        wr_data = {r_fg, r_bg, i_char_code};
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(i_cell_index);
        unique case (r_state)
            S_IDLE: begin
                wr_en = in_acc && is_put && !is_nl;
                rd_en = in_acc && (op == tccw_pkg::OP_READ) && in_range;
            end
            S_SCROLL: begin
                if (r_addr != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_addr - ADDR_W'(1);
                    wr_data = r_rd_data;
                end
                rd_en   = (r_addr != ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLS));
                rd_addr = r_addr + ADDR_W'(tccw_pkg::COLS);
            end
            S_ZERO: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
            end
            S_READ: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_ZERO;
            r_addr         <= '0;
            r_cur_row      <= '0;
            r_cur_col      <= '0;
            r_fg           <= tccw_pkg::FG_RESET;
            r_bg           <= tccw_pkg::BG_RESET;
            r_out_valid    <= 1'b0;
            r_rd_oob       <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (paddr[2] == tccw_pkg::CFG_BG) begin
                    r_bg <= pwdata[tccw_pkg::NIB_W-1:0];
                end else begin
                    r_fg <= pwdata[tccw_pkg::NIB_W-1:0];
                end
            end

            r_out_valid <= n_out_valid;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rd_oob <= !in_range;
                        unique case (op)
                            tccw_pkg::OP_PUT: begin
                                r_cursor_valid <= i_end_of_text;
                                r_cursor_index <= i_end_of_text
                                                ? tccw_pkg::IDX_W'(pos) : '0;
                                r_read_char    <= '0;
                                r_read_attr    <= '0;
                                r_cur_row      <= new_row;
                                r_cur_col      <= new_col;
                                if (ovf) begin
                                    r_state <= S_SCROLL;
                                    r_addr  <= '0;
                                end
                            end
                            tccw_pkg::OP_CLEAR: begin
                                r_cursor_valid <= 1'b1;
                                r_cursor_index <= '0;
                                r_read_char    <= '0;
                                r_read_attr    <= '0;
                                r_state        <= S_ZERO;
                                r_addr         <= '0;
                            end
                            tccw_pkg::OP_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                // Unused opcode: an all-zero word.
                                r_cursor_valid <= 1'b0;
                                r_cursor_index <= '0;
                                r_read_char    <= '0;
                                r_read_attr    <= '0;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_cursor_valid <= 1'b0;
                    r_cursor_index <= '0;
                    r_read_char    <= r_rd_oob ? '0 : r_rd_data[7:0];
                    r_read_attr    <= r_rd_oob ? '0 : r_rd_data[15:8];
                    r_state        <= S_IDLE;
                end
                S_SCROLL: begin
                    if (r_addr == ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLS)) begin
                        r_state <= S_ZERO;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_ZERO: begin
                    if (r_addr == ADDR_W'(tccw_pkg::CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
            endcase
        end
    end

    // The cursor never leaves the screen.
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) < tccw_pkg::ROWS) && (32'(r_cur_col) < tccw_pkg::COLS))
        else $error("cursor outside the screen");

    // A read word is answered through S_READ, which then loads the output register.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (op == tccw_pkg::OP_READ) |=> (r_state == S_READ) ##1 r_out_valid)
        else $error("read word not answered on time");

    // During the scroll copy the write never lands on the cell being fetched.
    a_scroll_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) && wr_en && rd_en |-> (wr_addr != rd_addr))
        else $error("scroll read and write hit the same cell");

    // The zeroing sweep ends on the last cell and returns to idle.
    a_zero_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZERO) && (r_addr == ADDR_W'(tccw_pkg::CELLS - 1)) |=> (r_state == S_IDLE))
        else $error("zeroing sweep did not finish");

    // The output register is only loaded when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a pending word");

endmodule
